### hw/rtl/bda_pkg.sv
// Package for the button debounce / auto-repeat block.
// Holds sizes, register codes and reset values and the configuration struct.
// No dependencies.
package bda_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int IN_W        = 4;
  localparam int CFG_W       = 10;
  localparam int CNT_W       = CFG_W + 1;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [CFG_W-1:0] HOLD_RESET    = CFG_W'(200);
  localparam logic [CFG_W-1:0] RELEASE_RESET = CFG_W'(20);

  // Register indexes (byte address is 4 * index)
  localparam logic REG_HOLD    = 1'b0;
  localparam logic REG_RELEASE = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] hold_count;
    logic [CFG_W-1:0] release_count;
  } cfg_t;

endpackage

### hw/rtl/bda_regs.sv
// APB-style configuration registers for the debounce block.
// Depends on bda_pkg (cfg_t, register codes, reset values).
module bda_regs
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_count    <= HOLD_RESET;
      cfg.release_count <= RELEASE_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_HOLD:    cfg.hold_count    <= pwdata[CFG_W-1:0];
        REG_RELEASE: cfg.release_count <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_HOLD:    prdata = DATA_W'(cfg.hold_count);
      REG_RELEASE: prdata = DATA_W'(cfg.release_count);
      default:     prdata = '0;
    endcase
  end

endmodule

### hw/rtl/bda_button.sv
// One button's signed hold/release counter and its press qualification.
// Depends on bda_pkg (cfg_t, CNT_W).
module bda_button
  import bda_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    held,
  input  cfg_t                    cfg,
  output logic                    report,
  output logic signed [CNT_W-1:0] cnt
);

  logic signed [CNT_W-1:0] cnt_next;
  logic signed [CNT_W-1:0] hold_s;
  logic signed [CNT_W-1:0] release_neg;

  assign hold_s      = signed'({1'b0, cfg.hold_count});
  assign release_neg = CNT_W'(0) - signed'({1'b0, cfg.release_count});

  always_comb begin
    cnt_next = cnt;
    report   = held;
    if (cnt > 0) begin
      if (held) begin
        // mask the press while the hold phase runs down
        cnt_next = cnt - CNT_W'(1);
        report   = 1'b0;
      end else begin
        cnt_next = release_neg;
      end
    end else if (cnt < 0) begin
      if (held) begin
        cnt_next = hold_s;
      end else begin
        cnt_next = cnt + CNT_W'(1);
      end
    end else if (held) begin
      cnt_next = hold_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt_next;
    end
  end

endmodule

### hw/rtl/button_debounce_autorepeat.sv
// Button debounce with auto-repeat, top level.
// Latency: the result of a poll is registered and valid in the cycle after the poll is accepted.
// Throughput: one poll per cycle while out_ready takes each result; the single output register frees as it is taken.
// Reset (rst, synchronous): counters zero, hold_count 200, release_count 20, no result.
// Depends on bda_pkg, bda_regs and bda_button.
module button_debounce_autorepeat
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   raw_pressed,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IN_W-1:0]   qualified_pressed,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t                    cfg;
  logic                    in_fire;
  logic [NUM_BUTTONS-1:0]  held;
  logic [NUM_BUTTONS-1:0]  report;
  logic [IN_W-1:0]         result;
  logic signed [CNT_W-1:0] cnt_all [NUM_BUTTONS];

  bda_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_button
    if (i < IN_W) begin : g_wired
      assign held[i] = raw_pressed[i];
    end else begin : g_unwired
      assign held[i] = 1'b0;
    end

    bda_button u_button (
      .clk    (clk),
      .rst    (rst),
      .step   (in_fire),
      .held   (held[i]),
      .cfg    (cfg),
      .report (report[i]),
      .cnt    (cnt_all[i])
    );
  end

  for (genvar j = 0; j < IN_W; j++) begin : g_result
    if (j < NUM_BUTTONS) begin : g_used
      assign result[j] = report[j];
    end else begin : g_empty
      assign result[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register holds until the downstream transaction completes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      qualified_pressed <= result;
    end
  end

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted poll produced no result");

  a_hold_masks: assert property (@(posedge clk) disable iff (rst)
    in_fire && held[0] && (cnt_all[0] > 0) |=> !qualified_pressed[0])
    else $error("held press not masked during hold phase");

  a_press_loads: assert property (@(posedge clk) disable iff (rst)
    in_fire && held[0] && (cnt_all[0] <= 0)
    |=> qualified_pressed[0] && (cnt_all[0] == signed'({1'b0, $past(cfg.hold_count)})))
    else $error("reported press did not load hold count");

  a_release_neg: assert property (@(posedge clk) disable iff (rst)
    in_fire && !held[0] && (cnt_all[0] > 0) |=> (cnt_all[0] <= 0))
    else $error("release during hold did not enter release phase");
`endif

endmodule
